// File: src/dcmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcmc_pkg;

  // Field and register widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned POWER_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned DIV_CNT_W = $clog2(SAMPLE_W);

  // Reset values
  localparam logic [SAMPLE_W-1:0] LIGHT_STEP_RESET = 12'h180;
  localparam logic [POWER_W-1:0]  MAX_POWER_RESET  = 4'd9;
  localparam logic [POWER_W-1:0]  POWER_RESET      = 4'd9;

  // Character codes
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_F = 8'h46;
  localparam logic [7:0] CHAR_R = 8'h52;
  localparam logic [7:0] CHAR_S = 8'h53;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER  = 1'b1;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_KEY  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [1:0] KEY_LIGHT = 2'd1;
  localparam logic [1:0] KEY_TIME  = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_LIGHT  = 2'd1;
  localparam logic [1:0] MODE_TIME   = 2'd2;

  localparam logic [2:0] ST_APPLIED = 3'd0;
  localparam logic [2:0] ST_ALREADY = 3'd1;
  localparam logic [2:0] ST_MODE    = 3'd2;
  localparam logic [2:0] ST_STOPPED = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [7:0]          char_code;
    logic [1:0]          key_code;
    logic [SAMPLE_W-1:0] light_sample;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]         direction;
    logic [1:0]         mode;
    logic [POWER_W-1:0] power_level;
    logic [POWER_W-1:0] forward_duty;
    logic [POWER_W-1:0] reverse_duty;
    logic               stop_hold;
    logic [2:0]         status;
  } rsp_item_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: src/dcmc_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module dcmc_divider (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [dcmc_pkg::SAMPLE_W-1:0]     dividend,
  input  wire logic [dcmc_pkg::SAMPLE_W-1:0]     divisor,
  output dcmc_pkg::div_stat_t                    stat,
  output logic      [dcmc_pkg::SAMPLE_W-1:0]     quotient
);

  logic [dcmc_pkg::SAMPLE_W-1:0]  rem;
  logic [dcmc_pkg::SAMPLE_W-1:0]  quo;
  logic [dcmc_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [dcmc_pkg::SAMPLE_W:0]    trial;

  // Trial subtract of the shifted remainder
  assign trial = {rem, quo[dcmc_pkg::SAMPLE_W-1]} - {1'b0, divisor};

  // Control: run one step per cycle, flag the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= dcmc_pkg::DIV_CNT_W'(dcmc_pkg::SAMPLE_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: shift in dividend bits, keep the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[dcmc_pkg::SAMPLE_W]) begin
        rem <= trial[dcmc_pkg::SAMPLE_W-1:0];
        quo <= {quo[dcmc_pkg::SAMPLE_W-2:0], 1'b1};
      end else begin
        rem <= {rem[dcmc_pkg::SAMPLE_W-2:0], quo[dcmc_pkg::SAMPLE_W-1]};
        quo <= {quo[dcmc_pkg::SAMPLE_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

`default_nettype wire

// File: src/dc_motor_mode_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Motor direction, mode and power controller.
// cmd channel (cmd_valid / cmd_stall) takes one item: a serial character, a
// key press or a control tick. rsp channel (rsp_valid / rsp_stall) returns
// one item per command: direction, mode, power level, duty per output, the
// stop-hold flag and a status code.
// cfg channel (cfg_valid / cfg_ready, always ready) writes light_step
// (index 0) and max_power (index 1); write only while no command is open.
// Items that need no division go straight to the done state and load their
// result into the output register once it is free. A light-mode tick with
// nonzero light_step first runs the restoring divider, one quotient bit per
// cycle, and then enters the done state. One command is open at a time:
// cmd_stall is high from acceptance until the result is loaded into the
// output register, so no new command is taken before that.
// When the receiver stalls, the result holds in the output register; the
// next command is still accepted, and its result waits until the register
// frees.
// Reset: stop, manual mode, power 9, ramp rising, light_step 384,
// max_power 9, output register empty.
module dc_motor_mode_controller (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_stall,
  input  wire dcmc_pkg::cmd_item_t                 cmd,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output dcmc_pkg::rsp_item_t                      rsp,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dcmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dcmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dcmc_pkg::seq_state_t state, state_next;

  logic [dcmc_pkg::SAMPLE_W-1:0] light_step;
  logic [dcmc_pkg::POWER_W-1:0]  max_power;
  logic [1:0]                    motor_direction;
  logic [1:0]                    control_mode;
  logic [dcmc_pkg::POWER_W-1:0]  power_store;
  logic                          ramp_rising;
  dcmc_pkg::cmd_item_t           item;

  logic [1:0]                    direction_next;
  logic [1:0]                    mode_next;
  logic [dcmc_pkg::POWER_W-1:0]  power_next;
  logic                          ramp_next;
  logic                          hold_next;
  logic [2:0]                    status_next;

  logic                          cmd_take;
  logic                          div_start;
  logic                          commit;
  logic                          need_div;
  dcmc_pkg::div_stat_t           div_stat;
  logic [dcmc_pkg::SAMPLE_W-1:0] quotient;

  logic [dcmc_pkg::POWER_W-1:0]  digit_power;
  logic [dcmc_pkg::SAMPLE_W-1:0] light_power;
  logic [dcmc_pkg::POWER_W:0]    ramp_power;
  logic [1:0]                    want_dir;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != dcmc_pkg::SEQ_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign commit    = (state == dcmc_pkg::SEQ_DONE) && (!rsp_valid || !rsp_stall);
  assign need_div  = (cmd.operation == dcmc_pkg::OP_TICK) &&
                     (control_mode == dcmc_pkg::MODE_LIGHT) && (light_step != '0);
  assign div_start = cmd_take && need_div;

  dcmc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cmd.light_sample),
    .divisor  (light_step),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcmc_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      dcmc_pkg::SEQ_IDLE: begin
        if (cmd_take) begin
          state_next = need_div ? dcmc_pkg::SEQ_DIV : dcmc_pkg::SEQ_DONE;
        end
      end
      dcmc_pkg::SEQ_DIV: begin
        if (div_stat.done) begin
          state_next = dcmc_pkg::SEQ_DONE;
        end
      end
      dcmc_pkg::SEQ_DONE: begin
        if (commit) begin
          state_next = dcmc_pkg::SEQ_IDLE;
        end
      end
      default: state_next = dcmc_pkg::SEQ_IDLE;
    endcase
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      item <= cmd;
    end
  end

  // Candidate power levels; the digit level is clamped to max_power here
  always_comb begin
    digit_power = (item.char_code[3:0] > max_power) ? max_power : item.char_code[3:0];
    light_power = (light_step == '0) ? {8'd0, max_power} : quotient;
    ramp_power  = ramp_next ? ({1'b0, power_store} + 1'b1) :
                  ((power_store == '0) ? '0 : ({1'b0, power_store} - 1'b1));
    want_dir    = (item.char_code == dcmc_pkg::CHAR_F) ? dcmc_pkg::DIR_FWD
                                                       : dcmc_pkg::DIR_REV;
  end

  // Decide the step
  always_comb begin
    direction_next = motor_direction;
    mode_next      = control_mode;
    power_next     = power_store;
    ramp_next      = ramp_rising;
    hold_next      = 1'b0;
    status_next    = dcmc_pkg::ST_IGNORED;
    if (power_store >= max_power) begin
      ramp_next = 1'b0;
    end else if (power_store == '0) begin
      ramp_next = 1'b1;
    end
    case (item.operation)
      dcmc_pkg::OP_CHAR: begin
        if (item.char_code inside {[dcmc_pkg::CHAR_0:dcmc_pkg::CHAR_9]}) begin
          if (control_mode != dcmc_pkg::MODE_MANUAL) begin
            status_next = dcmc_pkg::ST_MODE;
          end else if (motor_direction == dcmc_pkg::DIR_STOP) begin
            status_next = dcmc_pkg::ST_STOPPED;
          end else begin
            power_next  = digit_power;
            status_next = dcmc_pkg::ST_APPLIED;
          end
        end else if (item.char_code == dcmc_pkg::CHAR_F ||
                     item.char_code == dcmc_pkg::CHAR_R) begin
          if (motor_direction == want_dir) begin
            status_next = dcmc_pkg::ST_ALREADY;
          end else begin
            hold_next      = (motor_direction != dcmc_pkg::DIR_STOP);
            direction_next = want_dir;
            status_next    = dcmc_pkg::ST_APPLIED;
          end
        end else if (item.char_code == dcmc_pkg::CHAR_S) begin
          if (control_mode != dcmc_pkg::MODE_MANUAL) begin
            status_next = dcmc_pkg::ST_MODE;
          end else if (motor_direction == dcmc_pkg::DIR_STOP) begin
            status_next = dcmc_pkg::ST_ALREADY;
          end else begin
            direction_next = dcmc_pkg::DIR_STOP;
            status_next    = dcmc_pkg::ST_APPLIED;
          end
        end
        ramp_next = ramp_rising;
      end
      dcmc_pkg::OP_KEY: begin
        if (item.key_code == dcmc_pkg::KEY_LIGHT) begin
          mode_next   = (control_mode == dcmc_pkg::MODE_MANUAL) ? dcmc_pkg::MODE_LIGHT
                                                               : dcmc_pkg::MODE_MANUAL;
          status_next = dcmc_pkg::ST_APPLIED;
        end else if (item.key_code == dcmc_pkg::KEY_TIME) begin
          mode_next   = (control_mode == dcmc_pkg::MODE_MANUAL) ? dcmc_pkg::MODE_TIME
                                                               : dcmc_pkg::MODE_MANUAL;
          status_next = dcmc_pkg::ST_APPLIED;
        end
        ramp_next = ramp_rising;
      end
      dcmc_pkg::OP_TICK: begin
        if (control_mode == dcmc_pkg::MODE_LIGHT) begin
          power_next = (light_power > {8'd0, max_power}) ? max_power
                                                         : light_power[dcmc_pkg::POWER_W-1:0];
          ramp_next  = ramp_rising;
        end else if (control_mode == dcmc_pkg::MODE_TIME) begin
          power_next = (ramp_power > {1'b0, max_power}) ? max_power
                                                        : ramp_power[dcmc_pkg::POWER_W-1:0];
        end else begin
          ramp_next = ramp_rising;
        end
        if (control_mode == dcmc_pkg::MODE_LIGHT || control_mode == dcmc_pkg::MODE_TIME) begin
          status_next = dcmc_pkg::ST_APPLIED;
          if (motor_direction == dcmc_pkg::DIR_STOP) begin
            direction_next = dcmc_pkg::DIR_FWD;
          end
        end
      end
      default: begin
        ramp_next = ramp_rising;
      end
    endcase
  end

  // Commit the step and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_direction <= dcmc_pkg::DIR_STOP;
      control_mode    <= dcmc_pkg::MODE_MANUAL;
      power_store     <= dcmc_pkg::POWER_RESET;
      ramp_rising     <= 1'b1;
      rsp_valid       <= 1'b0;
    end else begin
      if (commit) begin
        motor_direction <= direction_next;
        control_mode    <= mode_next;
        power_store     <= power_next;
        ramp_rising     <= ramp_next;
        rsp_valid       <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.direction    <= direction_next;
      rsp.mode         <= mode_next;
      rsp.power_level  <= power_next;
      rsp.forward_duty <= (direction_next == dcmc_pkg::DIR_FWD) ? power_next : '0;
      rsp.reverse_duty <= (direction_next == dcmc_pkg::DIR_REV) ? power_next : '0;
      rsp.stop_hold    <= hold_next;
      rsp.status       <= status_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_step <= dcmc_pkg::LIGHT_STEP_RESET;
      max_power  <= dcmc_pkg::MAX_POWER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dcmc_pkg::CFG_LIGHT_STEP: light_step <= cfg_data;
        dcmc_pkg::CFG_MAX_POWER:  max_power  <= cfg_data[dcmc_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/dcmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dcmc_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                cmd_valid,
  input wire logic                                cmd_stall,
  input wire logic                                rsp_valid,
  input wire logic                                rsp_stall,
  input wire dcmc_pkg::rsp_item_t                 rsp
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // One command open at a time
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while another is open");

  // Drive one output side only
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.forward_duty == '0 || rsp.reverse_duty == '0))
    else $error("both drive outputs active");

  // Forward duty follows power level
  a_fwd_duty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.direction == dcmc_pkg::DIR_FWD |-> rsp.forward_duty == rsp.power_level)
    else $error("forward duty differs from power level");

  // Stop hold only on an applied reversal
  a_hold_applied: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.stop_hold |-> rsp.status == dcmc_pkg::ST_APPLIED &&
                                   rsp.direction != dcmc_pkg::DIR_STOP)
    else $error("stop hold without an applied reversal");

endmodule

bind dc_motor_mode_controller dcmc_checker u_dcmc_checker (.*);

`default_nettype wire

// File: verif/dc_motor_mode_controller_tb.sv
`timescale 1ns / 1ps

module dc_motor_mode_controller_tb;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cmd_valid = 1'b0;
  logic                            cmd_stall;
  dcmc_pkg::cmd_item_t             cmd       = '0;
  logic                            rsp_valid;
  logic                            rsp_stall = 1'b0;
  dcmc_pkg::rsp_item_t             rsp;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dcmc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dcmc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Motor state and limits as the block should hold them
  logic [1:0]                    dir_q;
  logic [1:0]                    mode_q;
  logic [dcmc_pkg::POWER_W-1:0]  power_q;
  logic                          ramp_up_q;
  logic [dcmc_pkg::SAMPLE_W-1:0] light_step_q;
  logic [dcmc_pkg::POWER_W-1:0]  max_power_q;

  dcmc_pkg::rsp_item_t motor_status_q[$];
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 59;
  int unsigned rsp_hold_left = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;

  dc_motor_mode_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [dcmc_pkg::POWER_W-1:0] clamp_power(int unsigned p);
    return (p > max_power_q) ? max_power_q : p[dcmc_pkg::POWER_W-1:0];
  endfunction

  // Advance the motor state by one item and return the status it reports
  function automatic dcmc_pkg::rsp_item_t step_motor(dcmc_pkg::cmd_item_t c);
    dcmc_pkg::rsp_item_t r;
    logic [1:0]          want;
    logic                hold;
    logic [2:0]          st;
    int unsigned         p;
    hold = 1'b0;
    st   = dcmc_pkg::ST_IGNORED;
    case (c.operation)
      dcmc_pkg::OP_CHAR: begin
        if (c.char_code >= dcmc_pkg::CHAR_0 && c.char_code <= dcmc_pkg::CHAR_9) begin
          if (mode_q != dcmc_pkg::MODE_MANUAL) begin
            st = dcmc_pkg::ST_MODE;
          end else if (dir_q == dcmc_pkg::DIR_STOP) begin
            st = dcmc_pkg::ST_STOPPED;
          end else begin
            power_q = clamp_power(int'(c.char_code - dcmc_pkg::CHAR_0));
            st = dcmc_pkg::ST_APPLIED;
          end
        end else if (c.char_code == dcmc_pkg::CHAR_F || c.char_code == dcmc_pkg::CHAR_R) begin
          want = (c.char_code == dcmc_pkg::CHAR_F) ? dcmc_pkg::DIR_FWD : dcmc_pkg::DIR_REV;
          if (dir_q == want) begin
            st = dcmc_pkg::ST_ALREADY;
          end else begin
            // a reversal passes through stop
            hold  = (dir_q != dcmc_pkg::DIR_STOP);
            dir_q = want;
            st    = dcmc_pkg::ST_APPLIED;
          end
        end else if (c.char_code == dcmc_pkg::CHAR_S) begin
          if (mode_q != dcmc_pkg::MODE_MANUAL) begin
            st = dcmc_pkg::ST_MODE;
          end else if (dir_q == dcmc_pkg::DIR_STOP) begin
            st = dcmc_pkg::ST_ALREADY;
          end else begin
            dir_q = dcmc_pkg::DIR_STOP;
            st = dcmc_pkg::ST_APPLIED;
          end
        end
      end
      dcmc_pkg::OP_KEY: begin
        if (c.key_code == dcmc_pkg::KEY_LIGHT) begin
          mode_q = (mode_q == dcmc_pkg::MODE_MANUAL) ? dcmc_pkg::MODE_LIGHT
                                                     : dcmc_pkg::MODE_MANUAL;
          st = dcmc_pkg::ST_APPLIED;
        end else if (c.key_code == dcmc_pkg::KEY_TIME) begin
          mode_q = (mode_q == dcmc_pkg::MODE_MANUAL) ? dcmc_pkg::MODE_TIME
                                                     : dcmc_pkg::MODE_MANUAL;
          st = dcmc_pkg::ST_APPLIED;
        end
      end
      dcmc_pkg::OP_TICK: begin
        if (mode_q == dcmc_pkg::MODE_LIGHT || mode_q == dcmc_pkg::MODE_TIME) begin
          if (dir_q == dcmc_pkg::DIR_STOP) dir_q = dcmc_pkg::DIR_FWD;
          if (mode_q == dcmc_pkg::MODE_LIGHT) begin
            // zero step saturates to the top level
            p = (light_step_q == 0) ? int'(max_power_q)
                                    : int'(c.light_sample / light_step_q);
          end else begin
            if (power_q >= max_power_q) ramp_up_q = 1'b0;
            else if (power_q == 0) ramp_up_q = 1'b1;
            if (ramp_up_q) p = power_q + 1;
            else p = (power_q == 0) ? 0 : power_q - 1;
          end
          power_q = clamp_power(p);
          st = dcmc_pkg::ST_APPLIED;
        end
      end
      default: st = dcmc_pkg::ST_IGNORED;
    endcase
    r.direction    = dir_q;
    r.mode         = mode_q;
    r.power_level  = power_q;
    r.forward_duty = (dir_q == dcmc_pkg::DIR_FWD) ? power_q : {dcmc_pkg::POWER_W{1'b0}};
    r.reverse_duty = (dir_q == dcmc_pkg::DIR_REV) ? power_q : {dcmc_pkg::POWER_W{1'b0}};
    r.stop_hold    = hold;
    r.status       = st;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Drive the result stall: a long hold-off when requested, else random
  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_stall     <= 1'b1;
      rsp_hold_left <= rsp_hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest predicted status
  always @(posedge clk) begin : check_status
    dcmc_pkg::rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (motor_status_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected item, expected none actual %h", $time, rsp);
      end else begin
        want = motor_status_q.pop_front();
        check_field("direction", 8'(want.direction), 8'(rsp.direction));
        check_field("mode", 8'(want.mode), 8'(rsp.mode));
        check_field("power_level", 8'(want.power_level), 8'(rsp.power_level));
        check_field("forward_duty", 8'(want.forward_duty), 8'(rsp.forward_duty));
        check_field("reverse_duty", 8'(want.reverse_duty), 8'(rsp.reverse_duty));
        check_field("stop_hold", 8'(want.stop_hold), 8'(rsp.stop_hold));
        check_field("status", 8'(want.status), 8'(rsp.status));
      end
    end
  end

  // Offer one item after random gaps and predict its result on acceptance
  task automatic send_cmd(logic [1:0] op, logic [7:0] ch, logic [1:0] key,
                          logic [dcmc_pkg::SAMPLE_W-1:0] sample);
    dcmc_pkg::cmd_item_t item;
    item.operation    = op;
    item.char_code    = ch;
    item.key_code     = key;
    item.light_sample = sample;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= item;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    motor_status_q.push_back(step_motor(item));
  endtask

  // Mostly commands that move the state; the rest noise
  task automatic send_random_cmd();
    int unsigned                   pick;
    logic [1:0]                    op;
    logic [7:0]                    ch;
    logic [1:0]                    key;
    logic [dcmc_pkg::SAMPLE_W-1:0] sample;
    pick   = $urandom_range(99);
    ch     = 8'($urandom_range(255));
    key    = 2'($urandom_range(3));
    sample = 12'($urandom_range(4095));
    if (pick < 40) begin
      op = dcmc_pkg::OP_CHAR;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: ch = 8'(dcmc_pkg::CHAR_0 + $urandom_range(9));
        5: ch = dcmc_pkg::CHAR_F;
        6: ch = dcmc_pkg::CHAR_R;
        7: ch = dcmc_pkg::CHAR_S;
        default: ;
      endcase
    end else if (pick < 55) begin
      op = dcmc_pkg::OP_KEY;
      if ($urandom_range(4) != 0) begin
        key = ($urandom_range(1) != 0) ? dcmc_pkg::KEY_LIGHT : dcmc_pkg::KEY_TIME;
      end
    end else if (pick < 95) begin
      op = dcmc_pkg::OP_TICK;
    end else begin
      op = dcmc_pkg::OP_NONE;
    end
    send_cmd(op, ch, key, sample);
  endtask

  // Drop valid and hold until every predicted status has arrived
  task automatic wait_all_status();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (motor_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [dcmc_pkg::CFG_IDX_W-1:0] idx,
                           logic [dcmc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == dcmc_pkg::CFG_LIGHT_STEP) light_step_q = data;
    else max_power_q = data[dcmc_pkg::POWER_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write both limits once the block is idle
  task automatic set_limits(logic [dcmc_pkg::SAMPLE_W-1:0] step,
                            logic [dcmc_pkg::POWER_W-1:0] top);
    wait_all_status();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(dcmc_pkg::CFG_LIGHT_STEP, step);
    write_reg(dcmc_pkg::CFG_MAX_POWER,
              {{(dcmc_pkg::CFG_DATA_W-dcmc_pkg::POWER_W){1'b0}}, top});
  endtask

  task automatic test_idle_commands();
    send_cmd(dcmc_pkg::OP_NONE, 8'hFF, 2'd3, 12'hFFF);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, 2'd3, 12'd0);
    send_cmd(dcmc_pkg::OP_TICK, 8'h00, 2'd0, 12'hFFF);
    send_cmd(dcmc_pkg::OP_CHAR, 8'h00, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, 8'hFF, 2'd0, 12'd0);
    // digit and stop while already stopped
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_0 + 8'd5, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_S, 2'd0, 12'd0);
  endtask

  task automatic test_manual_drive();
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_F, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_F, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_0, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_9, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_R, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_S, 2'd0, 12'd0);
  endtask

  task automatic test_mode_keys_and_ticks();
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_LIGHT, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_0 + 8'd3, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_S, 2'd0, 12'd0);
    // ticks from stop force forward
    send_cmd(dcmc_pkg::OP_TICK, 8'h00, 2'd0, 12'hFFF);
    send_cmd(dcmc_pkg::OP_TICK, 8'h00, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_TIME, 12'd0);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_TIME, 12'd0);
    send_cmd(dcmc_pkg::OP_TICK, 8'h00, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_R, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_LIGHT, 12'd0);
  endtask

  task automatic test_limit_registers();
    // zero step saturates the light power
    set_limits(12'd0, 4'd15);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_LIGHT, 12'd0);
    send_cmd(dcmc_pkg::OP_TICK, 8'h00, 2'd0, 12'd5);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_LIGHT, 12'd0);
    // stored power stays above a lowered limit until the next update
    set_limits(12'd4095, 4'd3);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_R, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_CHAR, dcmc_pkg::CHAR_0 + 8'd7, 2'd0, 12'd0);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_LIGHT, 12'd0);
    send_cmd(dcmc_pkg::OP_TICK, 8'h00, 2'd0, 12'hFFF);
    send_cmd(dcmc_pkg::OP_KEY, 8'h00, dcmc_pkg::KEY_LIGHT, 12'd0);
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned send_pct,
                                     int unsigned recv_pct,
                                     logic [dcmc_pkg::SAMPLE_W-1:0] step,
                                     logic [dcmc_pkg::POWER_W-1:0] top);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_limits(step, top);
    repeat (n) send_random_cmd();
  endtask

  // Hold the result side off long enough to back up the command side
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    rsp_hold_left = HOLD_OFF_CYCLES;
    repeat (12) send_random_cmd();
    wait_all_status();
  endtask

  initial begin
    dir_q        = dcmc_pkg::DIR_STOP;
    mode_q       = dcmc_pkg::MODE_MANUAL;
    power_q      = dcmc_pkg::POWER_RESET;
    ramp_up_q    = 1'b1;
    light_step_q = dcmc_pkg::LIGHT_STEP_RESET;
    max_power_q  = dcmc_pkg::MAX_POWER_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_commands();
    test_manual_drive();
    test_mode_keys_and_ticks();
    test_limit_registers();
    test_random_traffic(130, 21, 59, dcmc_pkg::LIGHT_STEP_RESET, dcmc_pkg::MAX_POWER_RESET);
    test_random_traffic(120, 21, 59, 12'd1, 4'd15);
    test_random_traffic(120, 59, 21, 12'd4095, 4'd1);
    test_random_traffic(130, 59, 21, 12'($urandom_range(256, 511)),
                        4'($urandom_range(2, 14)));
    test_random_traffic(120, 0, 0, 12'd0, 4'd15);
    test_random_traffic(130, 0, 0, 12'd300, 4'd15);
    test_output_backpressure();

    wait_all_status();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
